// File: design/trial_division_factorizer_defines.svh
// assertion macros shared by the factorizer modules
`ifndef TRIAL_DIVISION_FACTORIZER_DEFINES_SVH
`define TRIAL_DIVISION_FACTORIZER_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define TDF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge, reset included
`define TDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TDF_ASSERT(lbl, clk, rstn, prop, msg)
`define TDF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: design/tdf_pkg.sv
package tdf_pkg;

  // value bits that take part in the factoring
  localparam int unsigned VALUE_WIDTH = 32;

  // data and exponent widths of the words
  localparam int unsigned DW = 32;
  localparam int unsigned EW = 5;

  // step counter of the bit-serial divider
  localparam int unsigned STEP_W = $clog2(DW);

  localparam logic [DW-1:0] VALUE_MASK =
    (VALUE_WIDTH >= DW) ? {DW{1'b1}} : DW'((64'd1 << VALUE_WIDTH) - 64'd1);

  typedef struct packed {
    logic          start;
    logic [DW-1:0] dividend;
    logic [DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] quotient;
    logic [DW-1:0] remainder;
  } div_rsp_t;

endpackage

// File: design/tdf_divider.sv
`include "trial_division_factorizer_defines.svh"

module tdf_divider
  import tdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic              running_q, running_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [DW-1:0]     dvs_q, dvs_d;

  logic [DW:0]       shifted;
  logic [DW+1:0]     diff;

  // one restoring step: shift in the next dividend bit, try a subtract
  assign shifted = {rem_q, quo_q[DW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

  always_comb begin
    running_d = running_q;
    done_d    = 1'b0;
    step_d    = step_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    dvs_d     = dvs_q;
    if (req_i.start) begin
      running_d = 1'b1;
      step_d    = '0;
      rem_d     = '0;
      quo_d     = req_i.dividend;
      dvs_d     = req_i.divisor;
    end else if (running_q) begin
      if (!diff[DW+1]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DW - 1)) begin
        running_d = 1'b0;
        done_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      done_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      running_q <= running_d;
      done_q    <= done_d;
      step_q    <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

  // a new division never starts on top of a running one
  `TDF_ASSERT(a_no_restart, clk_i, rst_ni, running_q |-> !req_i.start, "divider restarted")
  // done is a single cycle pulse
  `TDF_ASSERT(a_done_pulse, clk_i, rst_ni, done_q |=> !done_q, "done held")
  // done only follows the final step
  `TDF_ASSERT(a_done_after_run, clk_i, rst_ni, done_q |-> $past(running_q), "done without run")

endmodule

// File: design/trial_division_factorizer.sv
// work: one run of the 32-step divider per trial division, plus hand-off;
//   one trial division per candidate up to sqrt(value), plus one per prime power
// throughput: one word at a time; busy stays high until its last result is out
// values below two give a single marker result in the cycle after start
// results are one-cycle strobes; the receiver cannot stall them
// reset: asynchronous active low, returns to idle with no result pending
`include "trial_division_factorizer_defines.svh"

module trial_division_factorizer
  import tdf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [DW-1:0] value_i,
  output logic          busy,
  output logic          result_valid_o,
  output logic [DW-1:0] prime_o,
  output logic [EW-1:0] exponent_o,
  output logic          last_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FINAL
  } state_e;

  state_e        state_q, state_d;

  // working registers of the factoring loop
  logic [DW-1:0] rem_q, rem_d;        // part of the value not yet factored
  logic [DW-1:0] trial_q, trial_d;    // current candidate divisor
  logic [EW-1:0] cnt_q, cnt_d;        // exponent being counted
  logic          counting_q, counting_d;

  // one result held back, since its last flag is known only later
  logic          pend_valid_q, pend_valid_d;
  logic [DW-1:0] pend_prime_q, pend_prime_d;
  logic [EW-1:0] pend_exp_q, pend_exp_d;

  // registered result word
  logic          res_valid_q, res_valid_d;
  logic [DW-1:0] res_prime_q, res_prime_d;
  logic [EW-1:0] res_exp_q, res_exp_d;
  logic          res_last_q, res_last_d;

  logic [DW-1:0] masked;
  logic [DW-1:0] trial_next;
  div_req_t      div_req;
  div_rsp_t      div_rsp;

  tdf_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign masked     = value_i & VALUE_MASK;
  assign trial_next = trial_q + DW'(1);

  always_comb begin
    state_d      = state_q;
    rem_d        = rem_q;
    trial_d      = trial_q;
    cnt_d        = cnt_q;
    counting_d   = counting_q;
    pend_valid_d = pend_valid_q;
    pend_prime_d = pend_prime_q;
    pend_exp_d   = pend_exp_q;
    res_valid_d  = 1'b0;
    res_prime_d  = res_prime_q;
    res_exp_d    = res_exp_q;
    res_last_d   = res_last_q;

    div_req.start    = 1'b0;
    div_req.dividend = rem_q;
    div_req.divisor  = trial_q;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (masked < DW'(2)) begin
            // no prime factors: marker result
            res_valid_d = 1'b1;
            res_prime_d = '0;
            res_exp_d   = '0;
            res_last_d  = 1'b1;
          end else begin
            rem_d            = masked;
            trial_d          = DW'(2);
            cnt_d            = '0;
            counting_d       = 1'b0;
            pend_valid_d     = 1'b0;
            div_req.start    = 1'b1;
            div_req.dividend = masked;
            div_req.divisor  = DW'(2);
            state_d          = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        if (div_rsp.done) begin
          if (!counting_q) begin
            // quotient below divisor means divisor squared exceeds the rest
            if (div_rsp.quotient < trial_q) begin
              if (rem_q > DW'(1)) begin
                if (pend_valid_q) begin
                  res_valid_d = 1'b1;
                  res_prime_d = pend_prime_q;
                  res_exp_d   = pend_exp_q;
                  res_last_d  = 1'b0;
                  state_d     = ST_FINAL;
                end else begin
                  // the value itself is prime
                  res_valid_d = 1'b1;
                  res_prime_d = rem_q;
                  res_exp_d   = EW'(1);
                  res_last_d  = 1'b1;
                  state_d     = ST_IDLE;
                end
              end else begin
                // fully factored: held result is the last one
                res_valid_d = 1'b1;
                res_prime_d = pend_prime_q;
                res_exp_d   = pend_exp_q;
                res_last_d  = 1'b1;
                state_d     = ST_IDLE;
              end
              pend_valid_d = 1'b0;
            end else if (div_rsp.remainder == '0) begin
              // divisor found: start dividing it out
              rem_d            = div_rsp.quotient;
              cnt_d            = EW'(1);
              counting_d       = 1'b1;
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.quotient;
            end else begin
              trial_d         = trial_next;
              div_req.start   = 1'b1;
              div_req.divisor = trial_next;
            end
          end else begin
            if (div_rsp.remainder == '0) begin
              rem_d            = div_rsp.quotient;
              cnt_d            = cnt_q + EW'(1);
              div_req.start    = 1'b1;
              div_req.dividend = div_rsp.quotient;
            end else begin
              // power exhausted: release the older result, hold this one
              if (pend_valid_q) begin
                res_valid_d = 1'b1;
                res_prime_d = pend_prime_q;
                res_exp_d   = pend_exp_q;
                res_last_d  = 1'b0;
              end
              pend_valid_d    = 1'b1;
              pend_prime_d    = trial_q;
              pend_exp_d      = cnt_q;
              counting_d      = 1'b0;
              trial_d         = trial_next;
              div_req.start   = 1'b1;
              div_req.divisor = trial_next;
            end
          end
        end
      end

      ST_FINAL: begin
        // leftover above one is a prime with exponent one
        res_valid_d = 1'b1;
        res_prime_d = rem_q;
        res_exp_d   = EW'(1);
        res_last_d  = 1'b1;
        state_d     = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      rem_q        <= '0;
      trial_q      <= DW'(2);
      cnt_q        <= '0;
      counting_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_prime_q <= '0;
      pend_exp_q   <= '0;
      res_valid_q  <= 1'b0;
      res_prime_q  <= '0;
      res_exp_q    <= '0;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      rem_q        <= rem_d;
      trial_q      <= trial_d;
      cnt_q        <= cnt_d;
      counting_q   <= counting_d;
      pend_valid_q <= pend_valid_d;
      pend_prime_q <= pend_prime_d;
      pend_exp_q   <= pend_exp_d;
      res_valid_q  <= res_valid_d;
      res_prime_q  <= res_prime_d;
      res_exp_q    <= res_exp_d;
      res_last_q   <= res_last_d;
    end
  end

  assign busy           = (state_q != ST_IDLE);
  assign result_valid_o = res_valid_q;
  assign prime_o        = res_prime_q;
  assign exponent_o     = res_exp_q;
  assign last_o         = res_last_q;

  // after the last word of an item the block is ready again
  `TDF_ASSERT(a_last_idle, clk_i, rst_ni, (result_valid_o && last_o) |-> !busy, "busy after last")
  // a result that is not last leaves the item still in progress
  `TDF_ASSERT(a_more_busy, clk_i, rst_ni, (result_valid_o && !last_o) |-> busy, "idle before last")
  // only the marker carries prime zero
  `TDF_ASSERT_ALWAYS(a_marker, clk_i,
    (result_valid_o && (prime_o == '0)) |-> (last_o && (exponent_o == '0)), "bad marker")

endmodule

// File: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdf_pkg::*;

  // longest quiet stretch allowed: the slowest word in this run is a prime
  // near one million, about 1000 trial divisors, each one run of the divider
  localparam int unsigned QUIET_LIMIT = 200000;
  localparam int unsigned RANDOM_WORDS = 82;
  localparam int unsigned DRAIN_CYCLES = 200;

  // one result word as the block shows it
  typedef struct packed {
    logic [DW-1:0] prime;
    logic [EW-1:0] exponent;
    logic          last;
  } factor_word_t;

  // holds the factor words still to come and checks each one on arrival
  class factor_scoreboard;
    factor_word_t expected_factors_q[$];
    int unsigned  mismatches;

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH %0t: %s", $realtime, msg);
    endfunction

    // factor one accepted word by trial division and queue its results
    function void note_value(logic [DW-1:0] value);
      logic [DW-1:0] rest;
      logic [63:0]   divisor;
      logic [EW-1:0] power;
      factor_word_t  found[$];
      factor_word_t  w;
      rest = value & VALUE_MASK;
      if (rest < 2) begin
        // no prime factors: a single marker word
        w = '{prime: '0, exponent: '0, last: 1'b1};
        expected_factors_q = {expected_factors_q, w};
        return;
      end
      divisor = 64'd2;
      while (divisor * divisor <= {32'd0, rest}) begin
        if (rest % divisor[DW-1:0] == 0) begin
          power = '0;
          while (rest % divisor[DW-1:0] == 0) begin
            rest = rest / divisor[DW-1:0];
            power = power + 1'b1;
          end
          w = '{prime: divisor[DW-1:0], exponent: power, last: 1'b0};
          found = {found, w};
        end
        divisor = divisor + 64'd1;
      end
      // what is left above one is a prime larger than the square root
      if (rest > 1) begin
        w = '{prime: rest, exponent: EW'(1), last: 1'b0};
        found = {found, w};
      end
      found[found.size()-1].last = 1'b1;
      expected_factors_q = {expected_factors_q, found};
    endfunction

    function void check_factor(logic [DW-1:0] prime, logic [EW-1:0] exponent,
                               logic last);
      factor_word_t want;
      if (expected_factors_q.size() == 0) begin
        flag($sformatf("unexpected word prime=%0d exp=%0d last=%0b",
                       prime, exponent, last));
        return;
      end
      want = expected_factors_q.pop_front();
      if (prime !== want.prime || exponent !== want.exponent || last !== want.last)
        flag($sformatf("expected prime=%0d exp=%0d last=%0b, got prime=%0d exp=%0d last=%0b",
                       want.prime, want.exponent, want.last, prime, exponent, last));
    endfunction

    function int unsigned pending();
      return expected_factors_q.size();
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic [DW-1:0] value_i;
  logic          busy;
  logic          result_valid_o;
  logic [DW-1:0] prime_o;
  logic [EW-1:0] exponent_o;
  logic          last_o;

  factor_scoreboard factor_sb = new;
  int unsigned      quiet_cycles;

  trial_division_factorizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .value_i       (value_i),
    .busy          (busy),
    .result_valid_o(result_valid_o),
    .prime_o       (prime_o),
    .exponent_o    (exponent_o),
    .last_o        (last_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // offer one word and hold it until the block takes it (start high, busy low)
  task automatic send_value(input logic [DW-1:0] v);
    start   <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy);
    factor_sb.note_value(v);
  endtask

  // idle the sender now and then, except inside the back-to-back stretch
  task automatic maybe_gap(input bit back_to_back);
    if (!back_to_back && $urandom_range(0, 99) < 12) begin
      start   <= 1'b0;
      value_i <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // random words kept cheap to factor: the block's time grows with the square
  // root of what is left once the small factors are gone
  function automatic logic [DW-1:0] pick_value();
    logic [63:0] product;
    logic [63:0] d;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      // smooth number with an optional cofactor below 2^16: reaches all 32 bits
      product = 64'd1;
      repeat ($urandom_range(1, 14)) begin
        d = 64'($urandom_range(2, 40));
        if (product * d <= 64'hFFFF_FFFF) product = product * d;
      end
      if ($urandom_range(0, 1)) begin
        d = 64'($urandom_range(2, 65535));
        if (product * d <= 64'hFFFF_FFFF) product = product * d;
      end
      return product[DW-1:0];
    end else if (kind < 85) begin
      return $urandom_range(0, 65535);
    end else if (kind < 92) begin
      return $urandom_range(0, 262143);
    end else if (kind < 96) begin
      // zero and one land here often
      return $urandom_range(0, 3);
    end else begin
      // pure prime power, large exponents
      d = 64'($urandom_range(2, 3));
      product = d;
      repeat ($urandom_range(1, 30)) begin
        if (product * d <= 64'hFFFF_FFFF) product = product * d;
      end
      return product[DW-1:0];
    end
  endfunction

  // result checking and the watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o) factor_sb.check_factor(prime_o, exponent_o, last_o);
      if ((start && !busy) || result_valid_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    logic [DW-1:0] directed_q[$];
    directed_q = '{
      32'd0,             // below two: marker
      32'd1,             // below two: marker
      32'd2,             // smallest prime, loop never runs
      32'd3,
      32'd4,             // prime square, nothing left after the loop
      32'd169,           // 13 squared
      32'd250,           // 2 * 5^3
      32'd65521,         // prime below 2^16
      32'd1000003,       // prime near one million, slowest word of the run
      32'd393126,        // 6 * 65521: large cofactor left after the loop
      32'hFFFF_FFFF,     // all ones: 3 * 5 * 17 * 257 * 65537
      32'h8000_0000,     // 2^31, widest exponent
      32'd3486784401,    // 3^20
      32'd223092870,     // nine distinct primes, the most results per word
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'd1047552,       // 1024 * 1023
      32'd12
    };

    rst_ni       <= 1'b0;
    start        <= 1'b0;
    value_i      <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_q[i]) begin
      maybe_gap(1'b0);
      send_value(directed_q[i]);
    end

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == RANDOM_WORDS / 2) begin
        // hold off until every outstanding factor word has come back
        start <= 1'b0;
        do @(posedge clk_i); while (factor_sb.pending() != 0);
      end else begin
        maybe_gap(i >= 15 && i < 45);
      end
      send_value(pick_value());
    end
    start <= 1'b0;

    // drain, then give a stray word time to show up
    while (factor_sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (factor_sb.pending() != 0)
      factor_sb.flag($sformatf("%0d factor words never arrived", factor_sb.pending()));
    if (factor_sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
